>>> src/slru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_pkg
// Shared types and codes for the segmented LRU tag and recency manager.
// ----------------------------------------------------------------------------
package slru_pkg;

  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned KEY_BITS_DEF = 48;
  localparam int unsigned FIELD_KEY_W  = 48;
  localparam int unsigned CAP_W        = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam logic             WB_RESET  = 1'b1;

  // configuration register indexes
  localparam logic CFG_PROT_CAP = 1'b0;
  localparam logic CFG_WB_EN    = 1'b1;

  // request actions
  localparam logic [1:0] ACT_ACCESS = 2'd0;
  localparam logic [1:0] ACT_FILL   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_FILL_FREE  = 3'd2;
  localparam logic [2:0] ST_FILL_REPL  = 3'd3;
  localparam logic [2:0] ST_FILL_FAIL  = 3'd4;
  localparam logic [2:0] ST_REMOVED    = 3'd5;
  localparam logic [2:0] ST_REM_MISS   = 3'd6;
  localparam logic [2:0] ST_KEY_THERE  = 3'd7;

  // command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_UNLINK,
    CMD_PUSH,
    CMD_WRITE,
    CMD_CLEAR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    seg;
    logic    dirty;
  } cmd_t;

  // priority chain carried cell to cell
  typedef struct packed {
    logic key_seen;
    logic free_seen;
    logic rank_seen;
  } chain_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_HUNLINK,
    S_DFIND,
    S_DUNLINK,
    S_DPUSH,
    S_HPUSH,
    S_FWRITE,
    S_FPUSH,
    S_VFIND,
    S_VUNLINK,
    S_RUNLINK,
    S_RCLEAR,
    S_DONE
  } state_e;

endpackage

>>> src/segmented_lru_block_cache_policy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_lru_block_cache_policy
// Two-segment LRU tag and recency manager built as a row of slot cells.
// ----------------------------------------------------------------------------
// Sequencing: one request at a time; in_stall_o is high outside the idle state,
//   and the next request is taken only after the result word has been loaded.
//   A fill with no free slot walks probationary ranks from the tail for a victim.
// Reset: all slots invalid, segment counts zero, capacity 32, write-back on.
module segmented_lru_block_cache_policy #(
  parameter int unsigned ENTRIES  = slru_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = slru_pkg::KEY_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [slru_pkg::FIELD_KEY_W-1:0]    block_key_i,
  input  logic                                dirty_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic [$clog2(ENTRIES)-1:0]          slot_o,
  output logic                                slot_dirty_o,
  output logic                                in_protected_o,
  output logic                                evicted_valid_o,
  output logic [slru_pkg::FIELD_KEY_W-1:0]    evicted_key_o,
  output logic                                evicted_dirty_o,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [slru_pkg::CAP_W-1:0]          cfg_data_i
);

  localparam int unsigned RW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = (CW > slru_pkg::CAP_W) ? CW : slru_pkg::CAP_W;
  localparam int unsigned KW = slru_pkg::FIELD_KEY_W;

  // configuration
  logic [slru_pkg::CAP_W-1:0] cap_q;
  logic                       wb_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= slru_pkg::CAP_RESET;
      wb_q  <= slru_pkg::WB_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == slru_pkg::CFG_PROT_CAP) begin
        cap_q <= cfg_data_i;
      end else begin
        wb_q <= cfg_data_i[0];
      end
    end
  end

  // effective protected capacity, clamped to 1..ENTRIES-1
  logic [WW-1:0] cap_eff, room;
  always_comb begin
    cap_eff = WW'(cap_q);
    if (cap_eff == '0) cap_eff = WW'(1);
    if (cap_eff >= WW'(ENTRIES)) cap_eff = WW'(ENTRIES - 1);
    room = WW'(ENTRIES) - cap_eff;
  end

  // sequencer state
  slru_pkg::state_e state_q, state_d;
  logic [1:0]          act_q;
  logic [KEY_BITS-1:0] key_q;
  logic                dirty_q;
  logic [ENTRIES-1:0]  a_q, a_d, b_q, b_d;
  logic                hseg_q, hseg_d;
  logic [CW-1:0]       pc_q, pc_d, pb_q, pb_d, r_q, r_d;
  logic [2:0]          stat_q, stat_d;
  logic                use_slot_q, use_slot_d;
  logic                rmd_q, rmd_d;
  logic                evv_q, evv_d, evd_q, evd_d;
  logic [KEY_BITS-1:0] evk_q, evk_d;

  // output register
  logic                out_v_q;
  logic [2:0]          o_stat_q;
  logic [RW-1:0]       o_slot_q;
  logic                o_sd_q, o_ip_q, o_evv_q, o_evd_q;
  logic [KW-1:0]       o_evk_q;

  // cell row
  slru_pkg::cmd_t     cmd;
  logic [RW-1:0]      cmd_rec;
  logic [ENTRIES-1:0] tgt;
  slru_pkg::chain_t   chain [ENTRIES+1];
  logic [ENTRIES-1:0] key_hit, free_hit, rank_hit;
  logic [KEY_BITS-1:0] tag_w [ENTRIES];
  logic [RW-1:0]       rec_w [ENTRIES];
  logic [ENTRIES-1:0]  seg_w, mod_w;

  assign chain[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    slru_cell #(
      .KEY_BITS (KEY_BITS),
      .RW       (RW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .sel_i      (tgt[g]),
      .cmd_i      (cmd),
      .cmd_rec_i  (cmd_rec),
      .key_i      (key_q),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .key_hit_o  (key_hit[g]),
      .free_hit_o (free_hit[g]),
      .rank_hit_o (rank_hit[g]),
      .tag_o      (tag_w[g]),
      .rec_o      (rec_w[g]),
      .seg_o      (seg_w[g]),
      .mod_o      (mod_w[g])
    );
  end

  // read-out mux: one-hot vector picks a cell
  logic [ENTRIES-1:0]  mvec;
  logic [KEY_BITS-1:0] m_tag;
  logic [RW-1:0]       m_rec, m_idx;
  logic                m_seg, m_mod, m_any;

  always_comb begin
    case (state_q)
      slru_pkg::S_LOOK:                    mvec = key_hit;
      slru_pkg::S_DFIND, slru_pkg::S_VFIND: mvec = rank_hit;
      slru_pkg::S_DUNLINK, slru_pkg::S_DPUSH: mvec = b_q;
      default:                             mvec = a_q;
    endcase
  end

  always_comb begin
    m_tag = '0;
    m_rec = '0;
    m_idx = '0;
    m_seg = 1'b0;
    m_mod = 1'b0;
    for (int j = 0; j < ENTRIES; j++) begin
      if (mvec[j]) begin
        m_tag = m_tag | tag_w[j];
        m_rec = m_rec | rec_w[j];
        m_idx = m_idx | RW'(j);
        m_seg = m_seg | seg_w[j];
        m_mod = m_mod | mod_w[j];
      end
    end
    m_any = |mvec;
  end

  logic accept, pb_room;
  assign in_stall_o = (state_q != slru_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pb_room    = (WW'(pb_q) < room);

  // next state, cell commands, count updates
  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    hseg_d     = hseg_q;
    r_d        = r_q;
    stat_d     = stat_q;
    use_slot_d = use_slot_q;
    rmd_d      = rmd_q;
    evv_d      = evv_q;
    evd_d      = evd_q;
    evk_d      = evk_q;
    pc_d       = pc_q;
    pb_d       = pb_q;
    cmd.op     = slru_pkg::CMD_NOP;
    cmd.seg    = m_seg;
    cmd.dirty  = dirty_q;
    cmd_rec    = m_rec;
    tgt        = a_q;

    case (state_q)
      slru_pkg::S_IDLE: begin
        if (accept && (action_i != slru_pkg::ACT_NONE)) begin
          state_d    = slru_pkg::S_LOOK;
          use_slot_d = 1'b0;
          rmd_d      = 1'b0;
          evv_d      = 1'b0;
          evd_d      = 1'b0;
          evk_d      = '0;
        end
      end

      slru_pkg::S_LOOK: begin
        case (act_q)
          slru_pkg::ACT_ACCESS: begin
            if (m_any) begin
              a_d        = key_hit;
              hseg_d     = m_seg;
              use_slot_d = 1'b1;
              stat_d     = slru_pkg::ST_HIT;
              state_d    = slru_pkg::S_HUNLINK;
            end else begin
              stat_d  = slru_pkg::ST_MISS;
              state_d = slru_pkg::S_DONE;
            end
          end
          slru_pkg::ACT_FILL: begin
            if (m_any) begin
              a_d        = key_hit;
              use_slot_d = 1'b1;
              stat_d     = slru_pkg::ST_KEY_THERE;
              state_d    = slru_pkg::S_DONE;
            end else if (pb_room && (|free_hit)) begin
              a_d        = free_hit;
              use_slot_d = 1'b1;
              stat_d     = slru_pkg::ST_FILL_FREE;
              state_d    = slru_pkg::S_FWRITE;
            end else begin
              r_d     = pb_q;
              state_d = slru_pkg::S_VFIND;
            end
          end
          default: begin
            if (m_any) begin
              a_d     = key_hit;
              rmd_d   = m_mod;
              stat_d  = slru_pkg::ST_REMOVED;
              state_d = slru_pkg::S_RUNLINK;
            end else begin
              stat_d  = slru_pkg::ST_REM_MISS;
              state_d = slru_pkg::S_DONE;
            end
          end
        endcase
      end

      slru_pkg::S_HUNLINK, slru_pkg::S_VUNLINK, slru_pkg::S_RUNLINK,
      slru_pkg::S_DUNLINK: begin
        cmd.op = slru_pkg::CMD_UNLINK;
        if (state_q == slru_pkg::S_DUNLINK) tgt = b_q;
        if (m_seg) begin
          if (pc_q != '0) pc_d = pc_q - CW'(1);
        end else begin
          if (pb_q != '0) pb_d = pb_q - CW'(1);
        end
        case (state_q)
          slru_pkg::S_HUNLINK: begin
            if (!hseg_q && (WW'(pc_q) >= cap_eff) && (pc_q != '0)) begin
              state_d = slru_pkg::S_DFIND;
            end else begin
              state_d = slru_pkg::S_HPUSH;
            end
          end
          slru_pkg::S_VUNLINK: state_d = slru_pkg::S_FWRITE;
          slru_pkg::S_RUNLINK: state_d = slru_pkg::S_RCLEAR;
          default:             state_d = slru_pkg::S_DPUSH;
        endcase
      end

      slru_pkg::S_DFIND: begin
        cmd.seg = 1'b1;
        cmd_rec = RW'(pc_q - CW'(1));
        if (m_any) begin
          b_d     = rank_hit;
          state_d = slru_pkg::S_DUNLINK;
        end else begin
          state_d = slru_pkg::S_HPUSH;
        end
      end

      slru_pkg::S_DPUSH: begin
        tgt     = b_q;
        cmd.op  = slru_pkg::CMD_PUSH;
        cmd.seg = 1'b0;
        pb_d    = pb_q + CW'(1);
        state_d = slru_pkg::S_HPUSH;
      end

      slru_pkg::S_HPUSH: begin
        cmd.op  = slru_pkg::CMD_PUSH;
        cmd.seg = 1'b1;
        pc_d    = pc_q + CW'(1);
        state_d = slru_pkg::S_DONE;
      end

      slru_pkg::S_FWRITE: begin
        cmd.op  = slru_pkg::CMD_WRITE;
        state_d = slru_pkg::S_FPUSH;
      end

      slru_pkg::S_FPUSH: begin
        cmd.op  = slru_pkg::CMD_PUSH;
        cmd.seg = 1'b0;
        pb_d    = pb_q + CW'(1);
        state_d = slru_pkg::S_DONE;
      end

      slru_pkg::S_VFIND: begin
        // walk probationary ranks from the tail, one per cycle
        cmd.seg = 1'b0;
        cmd_rec = RW'(r_q - CW'(1));
        if (r_q == '0) begin
          stat_d  = slru_pkg::ST_FILL_FAIL;
          state_d = slru_pkg::S_DONE;
        end else begin
          r_d = r_q - CW'(1);
          if (m_any && (!wb_q || !m_mod)) begin
            a_d        = rank_hit;
            evv_d      = 1'b1;
            evk_d      = m_tag;
            evd_d      = m_mod;
            use_slot_d = 1'b1;
            stat_d     = slru_pkg::ST_FILL_REPL;
            state_d    = slru_pkg::S_VUNLINK;
          end else if (!wb_q) begin
            stat_d  = slru_pkg::ST_FILL_FAIL;
            state_d = slru_pkg::S_DONE;
          end
        end
      end

      slru_pkg::S_RCLEAR: begin
        cmd.op  = slru_pkg::CMD_CLEAR;
        state_d = slru_pkg::S_DONE;
      end

      slru_pkg::S_DONE: begin
        if (!out_v_q || !out_stall_i) state_d = slru_pkg::S_IDLE;
      end

      default: state_d = slru_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slru_pkg::S_IDLE;
      pc_q    <= '0;
      pb_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      pb_q    <= pb_d;
      if (state_q == slru_pkg::S_DONE && (!out_v_q || !out_stall_i)) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      key_q   <= KEY_BITS'(block_key_i);
      dirty_q <= dirty_i;
    end
    a_q        <= a_d;
    b_q        <= b_d;
    hseg_q     <= hseg_d;
    r_q        <= r_d;
    stat_q     <= stat_d;
    use_slot_q <= use_slot_d;
    rmd_q      <= rmd_d;
    evv_q      <= evv_d;
    evd_q      <= evd_d;
    evk_q      <= evk_d;
    if (state_q == slru_pkg::S_DONE && (!out_v_q || !out_stall_i)) begin
      o_stat_q <= stat_q;
      o_slot_q <= use_slot_q ? m_idx : '0;
      o_sd_q   <= use_slot_q ? m_mod : rmd_q;
      o_ip_q   <= use_slot_q ? m_seg : 1'b0;
      o_evv_q  <= evv_q;
      o_evk_q  <= KW'(evk_q);
      o_evd_q  <= evd_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign status_o        = o_stat_q;
  assign slot_o          = o_slot_q;
  assign slot_dirty_o    = o_sd_q;
  assign in_protected_o  = o_ip_q;
  assign evicted_valid_o = o_evv_q;
  assign evicted_key_o   = o_evk_q;
  assign evicted_dirty_o = o_evd_q;

endmodule

>>> src/slru_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slru_cell
// One cache slot: tag, valid, modified, segment and rank, with match logic
// and a link in the first-match priority chains.
// ----------------------------------------------------------------------------
module slru_cell #(
  parameter int unsigned KEY_BITS = slru_pkg::KEY_BITS_DEF,
  parameter int unsigned RW       = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sel_i,
  input  slru_pkg::cmd_t       cmd_i,
  input  logic [RW-1:0]        cmd_rec_i,
  input  logic [KEY_BITS-1:0]  key_i,
  input  slru_pkg::chain_t     chain_i,
  output slru_pkg::chain_t     chain_o,
  output logic                 key_hit_o,
  output logic                 free_hit_o,
  output logic                 rank_hit_o,
  output logic [KEY_BITS-1:0]  tag_o,
  output logic [RW-1:0]        rec_o,
  output logic                 seg_o,
  output logic                 mod_o
);

  logic                valid_q, valid_d;
  logic                mod_q, mod_d;
  logic                seg_q, seg_d;
  logic [RW-1:0]       rec_q, rec_d;
  logic [KEY_BITS-1:0] tag_q, tag_d;
  logic                key_raw, rank_raw, same_seg;

  assign same_seg = valid_q && (seg_q == cmd_i.seg);
  assign key_raw  = valid_q && (tag_q == key_i);
  assign rank_raw = same_seg && (rec_q == cmd_rec_i);

  assign key_hit_o  = key_raw && !chain_i.key_seen;
  assign free_hit_o = !valid_q && !chain_i.free_seen;
  assign rank_hit_o = rank_raw && !chain_i.rank_seen;

  assign chain_o.key_seen  = chain_i.key_seen | key_raw;
  assign chain_o.free_seen = chain_i.free_seen | !valid_q;
  assign chain_o.rank_seen = chain_i.rank_seen | rank_raw;

  assign tag_o = tag_q;
  assign rec_o = rec_q;
  assign seg_o = seg_q;
  assign mod_o = mod_q;

  always_comb begin
    valid_d = valid_q;
    mod_d   = mod_q;
    seg_d   = seg_q;
    rec_d   = rec_q;
    tag_d   = tag_q;
    case (cmd_i.op)
      slru_pkg::CMD_UNLINK: begin
        if (!sel_i && same_seg && (rec_q > cmd_rec_i)) begin
          rec_d = rec_q - RW'(1);
        end
      end
      slru_pkg::CMD_PUSH: begin
        if (sel_i) begin
          seg_d = cmd_i.seg;
          rec_d = '0;
        end else if (same_seg) begin
          rec_d = rec_q + RW'(1);
        end
      end
      slru_pkg::CMD_WRITE: begin
        if (sel_i) begin
          valid_d = 1'b1;
          tag_d   = key_i;
          mod_d   = cmd_i.dirty;
        end
      end
      slru_pkg::CMD_CLEAR: begin
        if (sel_i) begin
          valid_d = 1'b0;
          mod_d   = 1'b0;
          seg_d   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mod_q   <= 1'b0;
      seg_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mod_q   <= mod_d;
      seg_q   <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    tag_q <= tag_d;
  end

endmodule
